>>> sv/pwlx_pkg.sv
package pwlx_pkg;

   localparam int FRAC_BITS = 12;
   localparam int COEF_BITS = 18;
   localparam int RES_BITS  = 8;
   localparam int NUM_SEGS  = 16;
   localparam int SEG_BITS  = 4;
   localparam int IP_BITS   = 5;
   localparam int OP_BITS   = 32;
   localparam int Q18_BITS  = COEF_BITS + 1;
   localparam int STEP_BITS = 15;
   localparam int PROD_BITS = STEP_BITS + RES_BITS;
   localparam int EXP_MAX_IP = COEF_BITS;

   localparam logic MODE_LOG2 = 1'b0;
   localparam logic MODE_EXP2 = 1'b1;

   localparam logic [Q18_BITS-1:0] LG_BASE [NUM_SEGS] = '{
      19'd0,      19'd22928,  19'd44545,  19'd64993,
      19'd84392,  19'd102844, 19'd120437, 19'd137249,
      19'd153344, 19'd168783, 19'd183616, 19'd197889,
      19'd211643, 19'd224915, 19'd237736, 19'd250137
   };
   localparam logic [STEP_BITS-1:0] LG_STEP [NUM_SEGS] = '{
      15'd22928, 15'd21617, 15'd20448, 15'd19399,
      15'd18452, 15'd17594, 15'd16811, 15'd16096,
      15'd15439, 15'd14833, 15'd14273, 15'd13754,
      15'd13271, 15'd12821, 15'd12401, 15'd12007
   };
   localparam logic [Q18_BITS-1:0] EX_BASE [NUM_SEGS] = '{
      19'd262144, 19'd251030, 19'd240387, 19'd230195,
      19'd220436, 19'd211090, 19'd202141, 19'd193571,
      19'd185364, 19'd177505, 19'd169979, 19'd162773,
      19'd155872, 19'd149263, 19'd142935, 19'd136875
   };
   localparam logic [STEP_BITS-1:0] EX_STEP [NUM_SEGS] = '{
      15'd11114, 15'd10643, 15'd10192, 15'd9760,
      15'd9346,  15'd8950,  15'd8570,  15'd8207,
      15'd7859,  15'd7526,  15'd7207,  15'd6901,
      15'd6608,  15'd6328,  15'd6060,  15'd5803
   };

   typedef struct packed {
      logic                mode;
      logic [OP_BITS-1:0]  operand;
   } req_type;

   typedef struct packed {
      logic [Q18_BITS-1:0] result;
      logic                invalid;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 mode;
      logic                 bad;
      logic                 big;
      logic [IP_BITS-1:0]   ip;
      logic [FRAC_BITS-1:0] code;
   } norm_type;

   typedef struct packed {
      logic                valid;
      logic                mode;
      logic                bad;
      logic                big;
      logic [IP_BITS-1:0]  ip;
      logic [Q18_BITS-1:0] q18;
   } interp_type;

endpackage

>>> sv/pwlx_norm.sv
module pwlx_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pwlx_pkg::req_type in_data,
   output pwlx_pkg::norm_type out_data
);

   logic                               lead_in;
   logic [pwlx_pkg::IP_BITS-1:0]       lead_pos_in;
   logic                               bad_in;
   logic                               big_in;

   logic                               valid_ff;
   logic                               mode_ff;
   logic                               bad_ff;
   logic                               big_ff;
   logic [pwlx_pkg::IP_BITS-1:0]       lead_ff;
   logic [pwlx_pkg::COEF_BITS-1:0]     op_ff;

   logic [pwlx_pkg::IP_BITS-1:0]       shamt;
   logic [pwlx_pkg::COEF_BITS-1:0]     norm_val;
   pwlx_pkg::norm_type                 out_in;
   pwlx_pkg::norm_type                 out_ff;

   always_comb begin
      lead_pos_in = '0;
      for (int b = 1; b < pwlx_pkg::COEF_BITS; b++) begin
         if (in_data.operand[b]) begin
            lead_pos_in = pwlx_pkg::IP_BITS'(b);
         end
      end
   end

   assign lead_in = in_data.operand[pwlx_pkg::COEF_BITS-1:0] != '0;
   assign bad_in  = (in_data.mode == pwlx_pkg::MODE_LOG2) &&
                    (!lead_in || in_data.operand[pwlx_pkg::OP_BITS-1:pwlx_pkg::COEF_BITS] != '0);
   assign big_in  = (in_data.mode == pwlx_pkg::MODE_EXP2) &&
                    (in_data.operand[pwlx_pkg::OP_BITS-1:pwlx_pkg::FRAC_BITS] >
                     (pwlx_pkg::OP_BITS-pwlx_pkg::FRAC_BITS)'(pwlx_pkg::EXP_MAX_IP));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      mode_ff <= in_data.mode;
      bad_ff  <= bad_in;
      big_ff  <= big_in;
      lead_ff <= lead_pos_in;
      op_ff   <= in_data.operand[pwlx_pkg::COEF_BITS-1:0];
   end

   assign shamt    = pwlx_pkg::IP_BITS'(pwlx_pkg::COEF_BITS - 1) - lead_ff;
   assign norm_val = op_ff << shamt;

   always_comb begin
      out_in.valid = valid_ff;
      out_in.mode  = mode_ff;
      out_in.bad   = bad_ff;
      out_in.big   = big_ff;
      if (mode_ff == pwlx_pkg::MODE_EXP2) begin
         out_in.ip   = op_ff[pwlx_pkg::FRAC_BITS +: pwlx_pkg::IP_BITS];
         out_in.code = op_ff[pwlx_pkg::FRAC_BITS-1:0];
      end else begin
         out_in.ip   = lead_ff;
         out_in.code = norm_val[pwlx_pkg::COEF_BITS-2 -: pwlx_pkg::FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.mode <= out_in.mode;
      out_ff.bad  <= out_in.bad;
      out_ff.big  <= out_in.big;
      out_ff.ip   <= out_in.ip;
      out_ff.code <= out_in.code;
   end

   assign out_data = out_ff;

endmodule

>>> sv/pwlx_interp.sv
module pwlx_interp (
   input  logic                 clock,
   input  logic                 reset,
   input  pwlx_pkg::norm_type   in_data,
   output pwlx_pkg::interp_type out_data
);

   localparam logic [pwlx_pkg::PROD_BITS-1:0] ROUND_HALF =
      pwlx_pkg::PROD_BITS'(1 << (pwlx_pkg::RES_BITS - 1));

   logic [pwlx_pkg::SEG_BITS-1:0]  seg;
   logic [pwlx_pkg::RES_BITS-1:0]  low;
   logic [pwlx_pkg::STEP_BITS-1:0] step_in;
   logic [pwlx_pkg::Q18_BITS-1:0]  base_in;
   logic [pwlx_pkg::PROD_BITS-1:0] prod_in;

   logic                           valid_ff;
   logic                           mode_ff;
   logic                           bad_ff;
   logic                           big_ff;
   logic [pwlx_pkg::IP_BITS-1:0]   ip_ff;
   logic [pwlx_pkg::Q18_BITS-1:0]  base_ff;
   logic [pwlx_pkg::PROD_BITS-1:0] prod_ff;

   logic [pwlx_pkg::PROD_BITS-1:0] prod_round;
   logic [pwlx_pkg::STEP_BITS-1:0] corr;
   logic [pwlx_pkg::Q18_BITS-1:0]  q18_in;
   pwlx_pkg::interp_type           out_ff;

   assign seg = in_data.code[pwlx_pkg::FRAC_BITS-1 -: pwlx_pkg::SEG_BITS];
   assign low = in_data.code[pwlx_pkg::RES_BITS-1:0];

   always_comb begin
      if (in_data.mode == pwlx_pkg::MODE_EXP2) begin
         step_in = pwlx_pkg::EX_STEP[seg];
         base_in = pwlx_pkg::EX_BASE[seg];
      end else begin
         step_in = pwlx_pkg::LG_STEP[seg];
         base_in = pwlx_pkg::LG_BASE[seg];
      end
   end

   assign prod_in = pwlx_pkg::PROD_BITS'(step_in) * pwlx_pkg::PROD_BITS'(low);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_data.valid;
      end
      mode_ff <= in_data.mode;
      bad_ff  <= in_data.bad;
      big_ff  <= in_data.big;
      ip_ff   <= in_data.ip;
      base_ff <= base_in;
      prod_ff <= prod_in;
   end

   assign prod_round = prod_ff + ROUND_HALF;
   assign corr       = prod_round[pwlx_pkg::RES_BITS +: pwlx_pkg::STEP_BITS];

   always_comb begin
      if (mode_ff == pwlx_pkg::MODE_EXP2) begin
         q18_in = base_ff - pwlx_pkg::Q18_BITS'(corr);
      end else begin
         q18_in = base_ff + pwlx_pkg::Q18_BITS'(corr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= valid_ff;
      end
      out_ff.mode <= mode_ff;
      out_ff.bad  <= bad_ff;
      out_ff.big  <= big_ff;
      out_ff.ip   <= ip_ff;
      out_ff.q18  <= q18_in;
   end

   assign out_data = out_ff;

endmodule

>>> sv/pwlx_final.sv
module pwlx_final (
   input  logic                 clock,
   input  logic                 reset,
   input  pwlx_pkg::interp_type in_data,
   output logic                 out_strobe,
   output pwlx_pkg::rsp_type    out_data
);

   localparam int SHIFT = pwlx_pkg::COEF_BITS - pwlx_pkg::FRAC_BITS;
   localparam int Q12_BITS = pwlx_pkg::FRAC_BITS + 1;
   localparam logic [pwlx_pkg::Q18_BITS:0] ROUND_HALF =
      (pwlx_pkg::Q18_BITS+1)'(1 << (SHIFT - 1));

   logic [pwlx_pkg::Q18_BITS:0]   q18_round;
   logic [Q12_BITS-1:0]           q12;
   logic [pwlx_pkg::Q18_BITS-1:0] log_res;
   logic [pwlx_pkg::Q18_BITS-1:0] exp_res;
   pwlx_pkg::rsp_type             rsp_in;

   logic                          strobe_ff;
   pwlx_pkg::rsp_type             rsp_ff;

   assign q18_round = (pwlx_pkg::Q18_BITS+1)'(in_data.q18) + ROUND_HALF;
   assign q12       = q18_round[SHIFT +: Q12_BITS];
   assign log_res   = pwlx_pkg::Q18_BITS'({in_data.ip, pwlx_pkg::FRAC_BITS'(0)}) +
                      pwlx_pkg::Q18_BITS'(q12);
   assign exp_res   = in_data.q18 >> in_data.ip;

   always_comb begin
      rsp_in.invalid = in_data.bad;
      if (in_data.bad || in_data.big) begin
         rsp_in.result = '0;
      end else if (in_data.mode == pwlx_pkg::MODE_EXP2) begin
         rsp_in.result = exp_res;
      end else begin
         rsp_in.result = log_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_data.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_data   = rsp_ff;

endmodule

>>> sv/pwl_log2_exp2_unit.sv
// Channel    Handshake           Payload    Transfer
// request    start, busy         req_data   rising edge with start high and busy low
// response   rsp_strobe          rsp_data   rising edge that ends the strobe cycle
//
// One item is taken in every cycle; busy is always low.
// Each result transfers in the same order as its request transfer.
// The pipeline has five register stages: leading-one search, normalising
// shift, table lookup and multiply, correction add, rounding or final shift.
// Synchronous reset clears the valid bits of every stage; data in flight is dropped.
// The receiver cannot stall, so the pipeline never holds.
module pwl_log2_exp2_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pwlx_pkg::req_type req_data,
   output logic              rsp_strobe,
   output pwlx_pkg::rsp_type rsp_data
);

   logic                 accept;
   pwlx_pkg::norm_type   norm_data;
   pwlx_pkg::interp_type interp_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   pwlx_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .out_data (norm_data)
   );

   pwlx_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .in_data  (norm_data),
      .out_data (interp_data)
   );

   pwlx_final u_final (
      .clock      (clock),
      .reset      (reset),
      .in_data    (interp_data),
      .out_strobe (rsp_strobe),
      .out_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("Accepted request did not produce a result after five cycles.");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 5))
      else $error("Result strobe without a matching request transfer.");

   a_invalid_log : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.invalid) |->
         ($past(req_data.mode, 5) == pwlx_pkg::MODE_LOG2 && rsp_data.result == '0))
      else $error("Invalid flag raised on an exponent request or with a non-zero result.");
`endif

endmodule
